// File: rtl/pti_pkg.sv
package pti_pkg;

   localparam int FEAT_W         = 16;
   localparam int ERR_W          = 8;
   localparam int RATE_W         = 15;
   localparam int MODE_W         = 2;
   localparam int CSR_ADDR_W     = 2;
   localparam int CSR_DATA_W     = 15;
   localparam int NUM_INPUTS_DEF = 4;
   localparam int PROD_W         = FEAT_W + ERR_W;
   localparam int SCALED_W       = PROD_W + RATE_W + 1;
   localparam int RSP_W          = FEAT_W + ERR_W;

   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_RATE       = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACTIVATION_MODE = 2'd1;

   localparam logic [RATE_W-1:0] RATE_RESET = 15'd26;
   localparam logic              KIND_TRAIN = 1'b1;

   localparam logic signed [FEAT_W-1:0] ONE_Q88  = 16'sd256;
   localparam logic signed [FEAT_W-1:0] ZERO_Q88 = 16'sd0;

   typedef enum logic [MODE_W-1:0] {
      ACT_STEP     = 2'd0,
      ACT_RELU     = 2'd1,
      ACT_IDENTITY = 2'd2,
      ACT_ONE      = 2'd3
   } act_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DOT,
      ST_ACT,
      ST_ERR,
      ST_MUL_ERR,
      ST_MUL_RATE,
      ST_UPDATE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic mul_err;
      logic mul_rate;
      logic update;
   } cell_ctl_type;

   typedef struct packed {
      cell_ctl_type cells;
      logic         act_load;
      logic         err_load;
      logic         out_load;
      logic         train;
   } ctrl_type;

endpackage

// File: rtl/perceptron_train_and_infer.sv
// A request is taken only in idle and passes the dot, activation, error and output states; a train
// request adds error multiply, rate multiply and weight update. The partial sum ripples one cell
// per cycle down the weight chain, then for train three update steps run in every cell.
// A waiting result sits in the output register while the next item is accepted and computed.
// Reset (synchronous, active high) clears the weights, the update rate to 26, mode to step.
module perceptron_train_and_infer import pti_pkg::*; #(
   parameter int NUM_INPUTS = NUM_INPUTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: feature_0 .. feature_(NUM_INPUTS-1), target, 16 bits each
   input  logic [FEAT_W*(NUM_INPUTS+1)-1:0] req_tdata,
   // req_tuser: kind
   input  logic                           req_tuser,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // rsp_tdata: activation_out [15:0], whole_error [23:16]
   output logic [RSP_W-1:0]               rsp_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_we,
   input  logic [CSR_ADDR_W-1:0]          csr_addr,
   input  logic [CSR_DATA_W-1:0]          csr_wdata
);

   localparam int ACC_W = 2 * FEAT_W + $clog2(NUM_INPUTS + 1);

   ctrl_type     ctrl;
   logic         out_free;

   logic [RATE_W-1:0] rate_ff;
   act_mode_type      mode_ff;

   logic signed [FEAT_W-1:0] target_ff;
   logic signed [FEAT_W-1:0] y_ff, y_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic [RSP_W-1:0]         rsp_data_ff;
   logic                     rsp_valid_ff;

   logic signed [ACC_W-1:0]   sums [0:NUM_INPUTS];
   logic signed [ACC_W-9:0]   shifted;
   logic signed [FEAT_W-1:0]  sum_sat;
   logic signed [FEAT_W:0]    diff;
   logic        [FEAT_W:0]    mag;
   logic        [FEAT_W-8:0]  quot;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
         mode_ff <= ACT_STEP;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_STEP_RATE:       rate_ff <= csr_wdata[RATE_W-1:0];
            CSR_ACTIVATION_MODE: mode_ff <= act_mode_type'(csr_wdata[MODE_W-1:0]);
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   pti_ctrl #(.NUM_INPUTS(NUM_INPUTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .out_free   (out_free),
      .req_tready (req_tready),
      .ctrl       (ctrl)
   );

   assign sums[0] = '0;

   for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_cell
      pti_cell #(.ACC_W(ACC_W)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctrl.cells),
         .feat_in (req_tdata[FEAT_W*i +: FEAT_W]),
         .sum_in  (sums[i]),
         .err     (err_ff),
         .rate    (rate_ff),
         .sum_out (sums[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (ctrl.cells.load) begin
         target_ff <= req_tdata[FEAT_W*NUM_INPUTS +: FEAT_W];
      end
      if (ctrl.act_load) begin
         y_ff <= y_in;
      end
      if (ctrl.err_load) begin
         err_ff <= err_in;
      end
   end

   // activation of the finished sum
   always_comb begin
      shifted = sums[NUM_INPUTS][ACC_W-1:8];
      if (shifted > (ACC_W-8)'(32767)) begin
         sum_sat = 16'sh7fff;
      end else if (shifted < -(ACC_W-8)'(32768)) begin
         sum_sat = 16'sh8000;
      end else begin
         sum_sat = shifted[FEAT_W-1:0];
      end
      case (mode_ff)
         ACT_STEP:     y_in = (sum_sat > ZERO_Q88) ? ONE_Q88 : ZERO_Q88;
         ACT_RELU:     y_in = (sum_sat > ZERO_Q88) ? sum_sat : ZERO_Q88;
         ACT_IDENTITY: y_in = sum_sat;
         default:      y_in = ONE_Q88;
      endcase
   end

   // whole-number error (zero for predict), truncated toward zero and saturated
   always_comb begin
      diff = (FEAT_W+1)'(target_ff) - (FEAT_W+1)'(y_ff);
      mag  = diff[FEAT_W] ? (FEAT_W+1)'(-diff) : diff;
      quot = mag[FEAT_W:8];
      if (!ctrl.train) begin
         err_in = '0;
      end else if (diff[FEAT_W]) begin
         err_in = (quot > (FEAT_W-7)'(128)) ? -8'sd128 : ERR_W'(-$signed({1'b0, quot}));
      end else begin
         err_in = (quot > (FEAT_W-7)'(127)) ? 8'sd127 : quot[ERR_W-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_data_ff <= {err_ff, y_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/pti_cell.sv
module pti_cell import pti_pkg::*; #(
   parameter int ACC_W = 2 * FEAT_W + 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cell_ctl_type               ctl,
   input  logic signed [FEAT_W-1:0]   feat_in,
   input  logic signed [ACC_W-1:0]    sum_in,
   input  logic signed [ERR_W-1:0]    err,
   input  logic        [RATE_W-1:0]   rate,
   output logic signed [ACC_W-1:0]    sum_out
);

   logic signed [FEAT_W-1:0]   feat_ff;
   logic signed [FEAT_W-1:0]   w_ff, w_in;
   logic signed [ACC_W-1:0]    sum_ff, sum_in_next;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [SCALED_W-1:0] scaled_ff;
   logic signed [2*FEAT_W-1:0] term;
   logic signed [31:0]         delta;
   logic signed [32:0]         wsum;

   always_comb begin
      term        = feat_ff * w_ff;
      sum_in_next = sum_in + ACC_W'(term);
      // floor of scaled / 256
      delta       = 32'(scaled_ff >>> 8);
      wsum        = 33'(w_ff) + 33'(delta);
      if (wsum > 33'sd32767) begin
         w_in = 16'sh7fff;
      end else if (wsum < -33'sd32768) begin
         w_in = 16'sh8000;
      end else begin
         w_in = wsum[FEAT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= '0;
      end else if (ctl.update) begin
         w_ff <= w_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         feat_ff <= feat_in;
      end
      if (ctl.mul_err) begin
         prod_ff <= err * feat_ff;
      end
      if (ctl.mul_rate) begin
         scaled_ff <= prod_ff * $signed({1'b0, rate});
      end
      // hand the partial sum to the next cell every cycle
      sum_ff <= sum_in_next;
   end

   assign sum_out = sum_ff;

endmodule

// File: rtl/pti_ctrl.sv
module pti_ctrl import pti_pkg::*; #(
   parameter int NUM_INPUTS = NUM_INPUTS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   input  logic     req_kind,
   input  logic     out_free,
   output logic     req_tready,
   output ctrl_type ctrl
);

   localparam int CNT_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             train_ff, train_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         train_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         train_ff <= train_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      train_in   = train_ff;
      req_tready = 1'b0;
      ctrl       = '0;
      ctrl.train = train_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctrl.cells.load = 1'b1;
               train_in        = (req_kind == KIND_TRAIN);
               cnt_in          = '0;
               state_in        = ST_DOT;
            end
         end
         ST_DOT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_INPUTS - 1)) begin
               state_in = ST_ACT;
            end
         end
         ST_ACT: begin
            ctrl.act_load = 1'b1;
            state_in      = ST_ERR;
         end
         ST_ERR: begin
            ctrl.err_load = 1'b1;
            state_in      = train_ff ? ST_MUL_ERR : ST_OUT;
         end
         ST_MUL_ERR: begin
            ctrl.cells.mul_err = 1'b1;
            state_in           = ST_MUL_RATE;
         end
         ST_MUL_RATE: begin
            ctrl.cells.mul_rate = 1'b1;
            state_in            = ST_UPDATE;
         end
         ST_UPDATE: begin
            ctrl.cells.update = 1'b1;
            state_in          = ST_OUT;
         end
         ST_OUT: begin
            // hold until the result register is free
            if (out_free) begin
               ctrl.out_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
